[hdl/derq_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// derq_pkg
// Shared types and constants for the disk elevator request queue.
// ---------------------------------------------------------------------------
package derq_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int BLOCKS_PER_CYL_DEF = 9;

    // Remainder of a block over the cylinder size fits in six bits.
    localparam int REM_W = 6;
    localparam int BLK_W = 12;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DISPATCH  = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [2:0] KIND_MAX = 3'd2;

    localparam logic ADDR_MAX_BLOCK = 1'b0;
    localparam logic ADDR_MAX_SIZE  = 1'b1;

    // Byte addresses of the registers on the configuration port.
    localparam logic [2:0] REG_MAX_BLOCK = 3'd0;
    localparam logic [2:0] REG_MAX_SIZE  = 3'd4;

    typedef struct packed {
        logic [15:0]      id;
        logic [2:0]       kind;
        logic [11:0]      blk;
        logic [13:0]      size;
        logic [31:0]      addr;
        logic [8:0]       cyl;
        logic [REM_W-1:0] rem;
    } entry_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_WRITE = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

endpackage
`default_nettype wire

[hdl/disk_elevator_request_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// disk_elevator_request_queue
// Sorted disk request table with C-LOOK dispatch, one result per item.
// ---------------------------------------------------------------------------
// The block keeps up to QUEUE_DEPTH pending requests in one synchronous
// memory, sorted by cylinder, and answers every item with exactly one result.
// An item's time in the block is set by the walk through that memory, which
// has one read and one write port. An add is accepted, its cylinder is found
// by the reciprocal divide, the table is scanned for a duplicate and the
// insert point, any later entries are moved up, the new entry is written and
// the result is delivered; a duplicate or a full table skips the move and the
// write, and an add into an empty table skips the scan and the move. A
// dispatch scans the table, moves later entries down when needed, and
// delivers; a dispatch from an empty table goes straight to deliver. The
// deliver step waits while the output register still holds a result that
// has not been taken.
// An item is taken only while no other item is in work; a finished result
// waits in the output register and does not block the next item.
// Configuration writes take effect at once and are meant for idle periods.
// ---------------------------------------------------------------------------
module disk_elevator_request_queue
    import derq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int BLOCKS_PER_CYLINDER = BLOCKS_PER_CYL_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // s_tdata: req_kind[2:0], req_id[18:3], blk_num[30:19],
    // xfer_size[44:31], data_address[76:45], head_cyl[85:77]
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [87:0]  s_tdata,
    // s_tuser: opcode
    input  wire logic         s_tuser,
    // m_tdata: out_kind[2:0], out_id[18:3], out_block[30:19], out_size[44:31],
    // out_address[76:45], out_cylinder[85:77], out_track[86],
    // out_sector[91:87], error_mask[95:92], chosen_slot[100:96],
    // pending_count[106:101]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,
    // m_tuser: status
    output logic [2:0]        m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [6:0] BPC_C  = 7'(BLOCKS_PER_CYLINDER);
    localparam logic [6:0] HALF_C = 7'(BLOCKS_PER_CYLINDER / 2);

    // Configuration registers.
    logic [11:0] max_block_reg;
    logic [13:0] max_size_reg;

    // Latched input item.
    logic        op_reg;
    logic [2:0]  kind_reg;
    logic [15:0] id_reg;
    logic [11:0] blk_reg;
    logic [13:0] size_reg;
    logic [31:0] addr_reg;
    logic [8:0]  cur_reg;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   issue_reg, issue_next;
    logic            iss_on_reg, iss_on_next;
    logic            rv_reg;
    logic [IW-1:0]   ridx_reg;
    logic            dup_reg, dup_next;
    logic            found_reg, found_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [IW-1:0]   slot_reg, slot_next;
    entry_t          pick_reg, pick_next;
    logic [2:0]      status_reg, status_next;
    logic [8:0]      ncyl_reg, ncyl_next;
    logic [REM_W-1:0] nrem_reg, nrem_next;

    // Table memory, one read and one write port, registered read data.
    entry_t          mem [QUEUE_DEPTH];
    entry_t          rdata_reg;
    logic [IW-1:0]   raddr;
    logic            we;
    logic [IW-1:0]   waddr;
    entry_t          wdata;

    // Divider for the cylinder of a newly added block.
    logic             div_start;
    logic [BLK_W-1:0] div_dividend;
    logic             div_done;
    logic [BLK_W-1:0] div_quo;
    logic [REM_W-1:0] div_rem;

    // Output register.
    logic          m_tvalid_reg, m_tvalid_next;
    logic [111:0]  m_tdata_reg, m_tdata_next;
    logic [2:0]    m_tuser_reg, m_tuser_next;

    logic          in_accept;
    logic          last_read;
    logic          out_free;
    logic [CW-1:0] cnt_after;
    logic [3:0]    err;
    logic [6:0]    sec2;
    logic [4:0]    sector;
    logic          track;
    logic [8:0]    slot_wide;
    entry_t        new_entry;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign last_read = rv_reg && (CW'(ridx_reg) == count_reg - 1'b1);

    // A block of zero maps to cylinder zero, like block one.
    assign div_dividend = (s_tdata[30:19] == '0) ? '0 : s_tdata[30:19] - 1'b1;
    assign div_start    = in_accept && (s_tuser == OP_ADD);

    derq_div #(
        .DIVISOR (BLOCKS_PER_CYLINDER)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        new_entry.id   = id_reg;
        new_entry.kind = kind_reg;
        new_entry.blk  = blk_reg;
        new_entry.size = size_reg;
        new_entry.addr = addr_reg;
        new_entry.cyl  = ncyl_reg;
        new_entry.rem  = nrem_reg;
    end

    // Result fields of the chosen request.
    always_comb
    begin
        err = 4'b0000;
        err[0] = pick_reg.kind > KIND_MAX;
        err[1] = pick_reg.id == '0;
        err[2] = (pick_reg.blk == '0) || (pick_reg.blk > max_block_reg);
        err[3] = (pick_reg.size > max_size_reg) || pick_reg.size[0];
        sec2   = {pick_reg.rem, 1'b0};
        if (sec2 > BPC_C)
        begin
            sec2 = sec2 - BPC_C;
        end
        sector    = sec2[4:0];
        track     = 7'(pick_reg.rem) > HALF_C;
        slot_wide = 9'(slot_reg);
        case (status_reg)
            ST_ADDED:    cnt_after = count_reg + 1'b1;
            ST_DISPATCH: cnt_after = count_reg - 1'b1;
            default:     cnt_after = count_reg;
        endcase
    end

    // Sequencer: divide, scan, shift, write back, deliver.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        iss_on_next   = 1'b0;
        dup_next      = dup_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        slot_next     = slot_reg;
        pick_next     = pick_reg;
        status_next   = status_reg;
        ncyl_next     = ncyl_reg;
        nrem_next     = nrem_reg;
        raddr         = issue_reg[IW-1:0];
        we            = 1'b0;
        waddr         = '0;
        wdata         = rdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    dup_next   = 1'b0;
                    found_next = 1'b0;
                    pos_next   = '0;
                    slot_next  = '0;
                    issue_next = '0;
                    if (s_tuser == OP_ADD)
                    begin
                        state_next = S_DIV;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        status_next = ST_DISPATCH;
                        iss_on_next = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    ncyl_next = (div_quo > 12'd511) ? 9'd511 : div_quo[8:0];
                    nrem_next = div_rem;
                    if (count_reg == '0)
                    begin
                        status_next = ST_ADDED;
                        state_next  = S_WRITE;
                    end
                    else
                    begin
                        iss_on_next = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (iss_on_reg)
                begin
                    issue_next  = issue_reg + 1'b1;
                    iss_on_next = (issue_reg != count_reg - 1'b1);
                end
                if (rv_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (rdata_reg.id == id_reg)
                        begin
                            dup_next = 1'b1;
                        end
                        // Insert behind every entry of equal or lower cylinder.
                        if (rdata_reg.cyl <= ncyl_reg)
                        begin
                            pos_next = CW'(ridx_reg) + 1'b1;
                        end
                    end
                    else
                    begin
                        // First entry at or above the heads; else the lowest.
                        if (!found_reg && (ridx_reg == '0 || rdata_reg.cyl >= cur_reg))
                        begin
                            pick_next = rdata_reg;
                            slot_next = ridx_reg;
                        end
                        if (!found_reg && rdata_reg.cyl >= cur_reg)
                        begin
                            found_next = 1'b1;
                        end
                    end
                end
                if (last_read)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (dup_next)
                        begin
                            status_next = ST_DUPLICATE;
                            state_next  = S_OUT;
                        end
                        else if (count_reg == DEPTH_C)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            status_next = ST_ADDED;
                            if (pos_next == count_reg)
                            begin
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                issue_next  = count_reg - 1'b1;
                                iss_on_next = 1'b1;
                                state_next  = S_SHIFT;
                            end
                        end
                    end
                    else if (CW'(slot_next) == count_reg - 1'b1)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        issue_next  = CW'(slot_next) + 1'b1;
                        iss_on_next = 1'b1;
                        state_next  = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // Each entry read is written back one place over in the next cycle.
                if (iss_on_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        issue_next  = issue_reg - 1'b1;
                        iss_on_next = (issue_reg != pos_reg);
                    end
                    else
                    begin
                        issue_next  = issue_reg + 1'b1;
                        iss_on_next = (issue_reg != count_reg - 1'b1);
                    end
                end
                if (rv_reg)
                begin
                    we = 1'b1;
                    if (op_reg == OP_ADD)
                    begin
                        waddr = ridx_reg + 1'b1;
                        if (CW'(ridx_reg) == pos_reg)
                        begin
                            state_next = S_WRITE;
                        end
                    end
                    else
                    begin
                        waddr = ridx_reg - 1'b1;
                        if (last_read)
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
            end

            S_WRITE:
            begin
                we         = 1'b1;
                waddr      = pos_reg[IW-1:0];
                wdata      = new_entry;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = '0;
                    if (status_reg == ST_DISPATCH)
                    begin
                        m_tdata_next[2:0]    = pick_reg.kind;
                        m_tdata_next[18:3]   = pick_reg.id;
                        m_tdata_next[30:19]  = pick_reg.blk;
                        m_tdata_next[44:31]  = pick_reg.size;
                        m_tdata_next[76:45]  = pick_reg.addr;
                        m_tdata_next[85:77]  = pick_reg.cyl;
                        m_tdata_next[86]     = track;
                        m_tdata_next[91:87]  = sector;
                        m_tdata_next[95:92]  = err;
                        m_tdata_next[100:96] = slot_wide[4:0];
                    end
                    m_tdata_next[106:101] = 6'(cnt_after);
                    count_next = cnt_after;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            iss_on_reg    <= 1'b0;
            rv_reg        <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            max_block_reg <= 12'd360;
            max_size_reg  <= 14'd9216;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            iss_on_reg   <= iss_on_next;
            rv_reg       <= iss_on_reg;
            m_tvalid_reg <= m_tvalid_next;
            if (psel && penable && pwrite)
            begin
                case (paddr[2])
                    ADDR_MAX_BLOCK: max_block_reg <= pwdata[11:0];
                    ADDR_MAX_SIZE:  max_size_reg  <= pwdata[13:0];
                    default:        max_block_reg <= max_block_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg    <= issue_reg[IW-1:0];
        issue_reg   <= issue_next;
        dup_reg     <= dup_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
        slot_reg    <= slot_next;
        pick_reg    <= pick_next;
        status_reg  <= status_next;
        ncyl_reg    <= ncyl_next;
        nrem_reg    <= nrem_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        if (in_accept)
        begin
            op_reg   <= s_tuser;
            kind_reg <= s_tdata[2:0];
            id_reg   <= s_tdata[18:3];
            blk_reg  <= s_tdata[30:19];
            size_reg <= s_tdata[44:31];
            addr_reg <= s_tdata[76:45];
            cur_reg  <= s_tdata[85:77];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? {18'd0, max_size_reg} : {20'd0, max_block_reg};

    // The table never holds more entries than it has rows.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    // Writes only happen while moving entries or storing a new one.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == S_SHIFT || state_reg == S_WRITE))
        else $error("table write outside shift or write");

    // A shift never reads the row it writes in the same cycle.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (we && iss_on_reg && state_reg == S_SHIFT) |-> (raddr != waddr))
        else $error("shift read and write collide");

    // Each finished item changes the count by at most one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count jumped");

endmodule
`default_nettype wire

[hdl/derq_div.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// derq_div
// Divides a block index by the cylinder size with a reciprocal multiply:
// the operand, the quotient and then the remainder are registered in turn.
// ---------------------------------------------------------------------------
module derq_div
    import derq_pkg::*;
#(
    parameter int DIVISOR = BLOCKS_PER_CYL_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [BLK_W-1:0] dividend,
    output logic                  done,
    output logic [BLK_W-1:0]      quotient,
    output logic [REM_W-1:0]      remainder
);

    // Seven guard bits keep the scaled reciprocal exact for every dividend
    // below 2**BLK_W and every divisor up to 64.
    localparam int SHIFT  = BLK_W + 7;
    localparam int PROD_W = BLK_W + SHIFT + 1;
    localparam int BACK_W = BLK_W + REM_W + 1;
    localparam logic [SHIFT:0] RECIP =
        (SHIFT+1)'(((1 << SHIFT) + DIVISOR - 1) / DIVISOR);
    localparam logic [REM_W:0] DIV_C = (REM_W+1)'(DIVISOR);

    logic [BLK_W-1:0]  num_reg;
    logic [BLK_W-1:0]  quo_reg, quo_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic              num_ok_reg;
    logic              quo_ok_reg;
    logic              done_reg;
    logic [PROD_W-1:0] prod;
    logic [BACK_W-1:0] back;
    logic [BACK_W-1:0] diff;

    always_comb
    begin
        prod     = PROD_W'(num_reg) * PROD_W'(RECIP);
        quo_next = prod[SHIFT +: BLK_W];
        back     = BACK_W'(quo_reg) * BACK_W'(DIV_C);
        diff     = BACK_W'(num_reg) - back;
        rem_next = diff[REM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ok_reg <= 1'b0;
            quo_ok_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            num_ok_reg <= start;
            quo_ok_reg <= num_ok_reg;
            done_reg   <= quo_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
        end
        if (num_ok_reg)
        begin
            quo_reg <= quo_next;
        end
        if (quo_ok_reg)
        begin
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // The remainder always stays below the divisor.
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < DIV_C))
        else $error("divider remainder out of range");

endmodule
`default_nettype wire

[tb/disk_elevator_request_queue_checker.sv]
// ---------------------------------------------------------------------------
// disk_elevator_request_queue_checker
// Watches both streams and the register port, predicts every result and
// compares it field by field with what the queue returns.
// ---------------------------------------------------------------------------
module disk_elevator_request_queue_checker
    import derq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [87:0]  s_tdata,
    input  wire logic         s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [111:0] m_tdata,
    input  wire logic [2:0]   m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    input  wire logic         pready,
    output int                fail_count,
    output int                awaited,
    output int                results_seen,
    output int                dispatch_seen,
    output int                dup_seen,
    output int                full_seen,
    output int                empty_seen
);

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int BPC = BLOCKS_PER_CYL_DEF;

    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  kind;
        logic [11:0] blk;
        logic [13:0] size;
        logic [31:0] addr;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  kind;
        logic [15:0] id;
        logic [11:0] blk;
        logic [13:0] size;
        logic [31:0] addr;
        logic [8:0]  cyl;
        logic        trk;
        logic [4:0]  sec;
        logic [3:0]  err;
        logic [4:0]  slot;
        logic [5:0]  count;
    } outcome_t;

    request_t table_q [DEPTH];
    int       held;
    logic [11:0] lim_block;
    logic [13:0] lim_size;
    outcome_t outcome_q [$];

    function automatic logic [8:0] cylinder_of(logic [11:0] blk);
        int c;
        if (blk == 0)
            return 9'd0;
        c = (int'(blk) - 1) / BPC;
        return (c > 511) ? 9'd511 : 9'(c);
    endfunction

    // Applies one accepted request to the table copy and returns its result.
    task automatic schedule_item(input logic op, input request_t rq, input logic [8:0] cur,
                                 output outcome_t o);
        bit dup;
        int pos;
        int slot;
        int r;
        int s;
        request_t e;
        dup = 0;
        o = '0;
        if (op == OP_ADD)
        begin
            for (int i = 0; i < held; i++)
                if (table_q[i].id == rq.id)
                    dup = 1;
            if (dup)
                o.status = ST_DUPLICATE;
            else if (held >= DEPTH)
                o.status = ST_FULL;
            else
            begin
                pos = held;
                while (pos > 0 && cylinder_of(table_q[pos-1].blk) > cylinder_of(rq.blk))
                begin
                    table_q[pos] = table_q[pos-1];
                    pos--;
                end
                table_q[pos] = rq;
                held++;
                o.status = ST_ADDED;
            end
            o.count = 6'(held);
            return;
        end
        if (held == 0)
        begin
            o.status = ST_EMPTY;
            return;
        end
        slot = 0;
        for (int i = 0; i < held; i++)
            if (cylinder_of(table_q[i].blk) >= cur)
            begin
                slot = i;
                break;
            end
        e = table_q[slot];
        r = (e.blk == 0) ? 0 : (int'(e.blk) - 1) % BPC;
        s = 2 * r;
        if (s > BPC)
            s -= BPC;
        o.status = ST_DISPATCH;
        o.kind = e.kind;
        o.id = e.id;
        o.blk = e.blk;
        o.size = e.size;
        o.addr = e.addr;
        o.cyl = cylinder_of(e.blk);
        o.trk = (r > BPC / 2);
        o.sec = 5'(s);
        o.err[0] = (e.kind > KIND_MAX);
        o.err[1] = (e.id == 0);
        o.err[2] = (e.blk < 1) || (e.blk > lim_block);
        o.err[3] = (e.size > lim_size) || e.size[0];
        o.slot = 5'(slot);
        for (int i = slot; i + 1 < held; i++)
            table_q[i] = table_q[i+1];
        held--;
        o.count = 6'(held);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        outcome_t w;
        request_t rq;
        if (!rst_n)
        begin
            held = 0;
            lim_block = 12'd360;
            lim_size = 14'd9216;
            outcome_q.delete();
            fail_count = 0;
            results_seen = 0;
            dispatch_seen = 0;
            dup_seen = 0;
            full_seen = 0;
            empty_seen = 0;
        end
        else
        begin
            // Results are checked before the input of the same edge is predicted.
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (outcome_q.size() == 0)
                begin
                    $display("MISMATCH at %0t: result with nothing outstanding", $realtime);
                    fail_count++;
                end
                else
                begin
                    w = outcome_q.pop_front();
                    o = '{m_tuser, m_tdata[2:0], m_tdata[18:3], m_tdata[30:19],
                          m_tdata[44:31], m_tdata[76:45], m_tdata[85:77], m_tdata[86],
                          m_tdata[91:87], m_tdata[95:92], m_tdata[100:96], m_tdata[106:101]};
                    if (o.status != w.status) report("status", o.status, w.status);
                    if (o.kind != w.kind)     report("out_kind", o.kind, w.kind);
                    if (o.id != w.id)         report("out_id", o.id, w.id);
                    if (o.blk != w.blk)       report("out_block", o.blk, w.blk);
                    if (o.size != w.size)     report("out_size", o.size, w.size);
                    if (o.addr != w.addr)     report("out_address", o.addr, w.addr);
                    if (o.cyl != w.cyl)       report("out_cylinder", o.cyl, w.cyl);
                    if (o.trk != w.trk)       report("out_track", o.trk, w.trk);
                    if (o.sec != w.sec)       report("out_sector", o.sec, w.sec);
                    if (o.err != w.err)       report("error_mask", o.err, w.err);
                    if (o.slot != w.slot)     report("chosen_slot", o.slot, w.slot);
                    if (o.count != w.count)   report("pending_count", o.count, w.count);
                    case (w.status)
                        ST_DISPATCH:  dispatch_seen++;
                        ST_DUPLICATE: dup_seen++;
                        ST_FULL:      full_seen++;
                        ST_EMPTY:     empty_seen++;
                        default: ;
                    endcase
                end
            end
            if (s_tvalid && s_tready)
            begin
                rq = '{s_tdata[18:3], s_tdata[2:0], s_tdata[30:19], s_tdata[44:31],
                       s_tdata[76:45]};
                schedule_item(s_tuser, rq, s_tdata[85:77], o);
                outcome_q.push_back(o);
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == REG_MAX_BLOCK)
                    lim_block = pwdata[11:0];
                else if (paddr == REG_MAX_SIZE)
                    lim_size = pwdata[13:0];
            end
        end
        awaited = outcome_q.size();
    end

endmodule

[tb/disk_elevator_request_queue_tb.sv]
// ---------------------------------------------------------------------------
// disk_elevator_request_queue_tb
// Stimulus and verdict for the disk elevator request queue.
// ---------------------------------------------------------------------------
// Directed items cover the field extremes, empty dispatch, duplicates, a full
// table, bad blocks and one long receiver stall; random phases then mix adds
// and dispatches under several register settings, with random gaps on both
// streams and drains between phases. The checker does all prediction.
// ---------------------------------------------------------------------------
module disk_elevator_request_queue_tb
    import derq_pkg::*;
();

    // An add walks the whole table at most twice plus the divide; allow a margin.
    localparam int SETTLE_CYCLES = 150;
    localparam int STALL_LIMIT = 6000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [87:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int awaited;
    int results_seen;
    int dispatch_seen;
    int dup_seen;
    int full_seen;
    int empty_seen;

    // Current limits, so random items can mostly stay legal.
    int  cur_max_block;
    int  cur_max_size;
    // The stimulus raises hold_requests to make the receiver hold off for a
    // long time; the receiver counts the holds it has served.
    int  hold_requests;
    int  hold_served;
    int  idle_cycles;

    disk_elevator_request_queue DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    disk_elevator_request_queue_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .awaited(awaited), .results_seen(results_seen),
        .dispatch_seen(dispatch_seen), .dup_seen(dup_seen), .full_seen(full_seen),
        .empty_seen(empty_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: any stretch with no item accepted on either side for too long
    // means the block has hung.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: a random wait before each result, and one
    // long hold-off on request so the block backs up into its input.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        hold_served = 0;
        @(posedge clk iff rst_n);
        forever
        begin
            gap = $urandom_range(0, 5);
            if (hold_requests != hold_served)
            begin
                gap = 400;
                hold_served++;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(negedge clk); while (!m_tvalid);
            @(posedge clk);
        end
    end

    task automatic send_item(input logic op, input logic [2:0] kind, input logic [15:0] id,
                             input logic [11:0] blk, input logic [13:0] size,
                             input logic [31:0] addr, input logic [8:0] cur);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, cur, addr, size, blk, id, kind};
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
    endtask

    // Stops offering items until every expected result is back, then lets
    // the block finish any internal walk.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input int blk_lim, input int size_lim);
        write_reg(REG_MAX_BLOCK, 32'(blk_lim));
        write_reg(REG_MAX_SIZE, 32'(size_lim));
        cur_max_block = blk_lim;
        cur_max_size = size_lim;
    endtask

    task automatic random_item(input int add_pct);
        logic [2:0]  kind;
        logic [15:0] id;
        logic [11:0] blk;
        logic [13:0] size;
        logic [8:0]  cur;
        int          pick;
        pick = $urandom_range(0, 99);
        kind = (pick < 85) ? 3'($urandom_range(0, 2)) : 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        // A small id pool makes duplicates common; the rest reach every bit.
        if (pick < 70)
            id = 16'($urandom_range(1, 60));
        else if (pick < 73)
            id = 16'd0;
        else
            id = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        blk = (pick < 75) ? 12'($urandom_range(1, cur_max_block)) : 12'($urandom_range(0, 4095));
        pick = $urandom_range(0, 99);
        size = (pick < 75) ? 14'($urandom_range(0, cur_max_size) & ~1)
                           : 14'($urandom_range(0, 16383));
        pick = $urandom_range(0, 99);
        cur = (pick < 75) ? 9'($urandom_range(0, (cur_max_block + 8) / 9))
                          : 9'($urandom_range(0, 511));
        send_item(($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_DISPATCH,
                  kind, id, blk, size, $urandom, cur);
    endtask

    initial
    begin
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_requests = 0;
        cur_max_block = 360;
        cur_max_size = 9216;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset limits.
        send_item(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 14'd0, 32'd0, 9'd0);   // empty table
        send_item(OP_ADD, 3'd7, 16'hFFFF, 12'd4095, 14'd16383, 32'hFFFF_FFFF, 9'd511);
        send_item(OP_ADD, 3'd0, 16'd0, 12'd0, 14'd0, 32'd0, 9'd0);        // block zero, id zero
        send_item(OP_ADD, 3'd1, 16'd5, 12'd360, 14'd9216, 32'h1234_5678, 9'd0);
        send_item(OP_ADD, 3'd2, 16'd6, 12'd361, 14'd9217, 32'h8765_4321, 9'd0);
        send_item(OP_ADD, 3'd2, 16'd5, 12'd10, 14'd2, 32'd1, 9'd0);       // duplicate id
        send_item(OP_ADD, 3'd1, 16'd7, 12'd1, 14'd2, 32'd2, 9'd0);
        send_item(OP_ADD, 3'd0, 16'd8, 12'd9, 14'd4, 32'd3, 9'd0);
        send_item(OP_ADD, 3'd0, 16'd9, 12'd14, 14'd4, 32'd4, 9'd0);
        send_item(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 14'd0, 32'd0, 9'd40);  // mid-table pick
        send_item(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 14'd0, 32'd0, 9'd511); // wraps to slot 0
        send_item(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 14'd0, 32'd0, 9'd0);
        for (int i = 0; i < 6; i++)
            send_item(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 14'd0, 32'd0, 9'($urandom_range(0, 511)));
        drain();

        // Fill the table past its depth, then offer a held id while full.
        set_limits(4095, 16383);
        for (int i = 1; i <= 34; i++)
            send_item(OP_ADD, 3'($urandom_range(0, 2)), 16'(i), 12'($urandom_range(0, 4095)),
                      14'($urandom_range(0, 16383)), $urandom, 9'd0);
        send_item(OP_ADD, 3'd0, 16'd3, 12'd100, 14'd0, 32'd0, 9'd0);
        // Hold the output off while the sender keeps pushing dispatches.
        hold_requests = hold_requests + 1;
        for (int i = 0; i < 40; i++)
            send_item(OP_DISPATCH, 3'd0, 16'd0, 12'd0, 14'd0, 32'd0, 9'($urandom_range(0, 511)));
        drain();

        // Random phases, each under its own limits and add mix.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: set_limits(1, 0);
                1: set_limits(4095, 16383);
                2: set_limits(360, 9216);
                default: set_limits($urandom_range(1, 4095), $urandom_range(0, 16383));
            endcase
            for (int i = 0; i < 135; i++)
                random_item((ph % 3 == 0) ? 75 : (ph % 3 == 1) ? 50 : 35);
            drain();
        end

        $display("Checked %0d results: %0d dispatches, %0d duplicates, %0d full refusals,",
                 results_seen, dispatch_seen, dup_seen, full_seen);
        $display("%0d empty dispatches, over several limit settings and one long output stall.",
                 empty_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
hdl/derq_pkg.sv
hdl/derq_div.sv
hdl/disk_elevator_request_queue.sv
tb/disk_elevator_request_queue_checker.sv
tb/disk_elevator_request_queue_tb.sv
